FILE: sv/elg_pkg.sv
// Shared constants, codes and token control type for the edge list graph table.
`timescale 1ns / 1ps

package elg_pkg;

   // Default sizes
   localparam int MAX_EDGES_DEF   = 512;
   localparam int VERTEX_BITS_DEF = 8;

   // Fixed field widths
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;
   localparam int VCOUNT_W   = 8;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 1;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0] OP_DEGREE = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIRECTED     = 1'd1;

   // Register reset values
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 8'd255;

   // Control part of the token that walks the cell chain
   typedef struct packed {
      logic            valid;
      logic [OP_W-1:0] op;
      logic            ins;     // insert with both endpoints in range
      logic            found;   // a matching edge was seen so far
      logic            stored;  // the insert was written into a cell
   } elg_ctl_type;

endpackage

FILE: sv/elg_if.sv
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps

interface elg_req_if
   import elg_pkg::*;
   #(parameter int VB = VERTEX_BITS_DEF)
   ();
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] operation;
   logic [VB-1:0]   first_vertex;
   logic [VB-1:0]   second_vertex;

   modport source (output valid, operation, first_vertex, second_vertex, input ready);
   modport sink   (input valid, operation, first_vertex, second_vertex, output ready);
endinterface

interface elg_rsp_if
   import elg_pkg::*;
   #(parameter int CNT_W = 10,
     parameter int DEG_W = 11)
   ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                found;
   logic [DEG_W-1:0]    degree_count;
   logic [CNT_W-1:0]    edges_held;

   modport source (output valid, status, found, degree_count, edges_held, input ready);
   modport sink   (input valid, status, found, degree_count, edges_held, output ready);
endinterface

FILE: sv/elg_cell.sv
// One chain cell: holds one edge, matches and counts the passing token, stores inserts.
`timescale 1ns / 1ps

module elg_cell
   import elg_pkg::*;
   #(parameter int IDX   = 0,
     parameter int VB    = VERTEX_BITS_DEF,
     parameter int CNT_W = 10,
     parameter int DEG_W = 11)
   (
   input  logic              clock,
   input  logic              reset,
   input  logic [CNT_W-1:0]  edge_total,
   input  logic              directed,
   input  elg_ctl_type       ctl_i,
   input  logic [VB-1:0]     a_i,
   input  logic [VB-1:0]     b_i,
   input  logic [DEG_W-1:0]  deg_i,
   output elg_ctl_type       ctl_o,
   output logic [VB-1:0]     a_o,
   output logic [VB-1:0]     b_o,
   output logic [DEG_W-1:0]  deg_o
   );

   localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

   logic [VB-1:0]    head_ff;
   logic [VB-1:0]    tail_ff;
   elg_ctl_type      ctl_ff;
   elg_ctl_type      ctl_in;
   logic [VB-1:0]    a_ff;
   logic [VB-1:0]    b_ff;
   logic [DEG_W-1:0] deg_ff;
   logic [DEG_W-1:0] deg_in;
   logic             occupied;
   logic             hit;
   logic             store;

   // Match this cell's edge against the token
   always_comb begin
      occupied = IDX_C < edge_total;
      hit      = ctl_i.valid && occupied &&
                 ((head_ff == a_i && tail_ff == b_i) ||
                  (!directed && head_ff == b_i && tail_ff == a_i));
      store    = ctl_i.valid && ctl_i.ins && !ctl_i.found && !ctl_i.stored &&
                 (IDX_C == edge_total);
      ctl_in        = ctl_i;
      ctl_in.found  = ctl_i.found | hit;
      ctl_in.stored = ctl_i.stored | store;
      deg_in = deg_i;
      if (ctl_i.valid && occupied && ctl_i.op == OP_DEGREE) begin
         deg_in = deg_i + DEG_W'(head_ff == a_i) + DEG_W'(tail_ff == a_i);
      end
   end

   // Capture the edge at the first free slot
   always_ff @(posedge clock) begin
      if (store) begin
         head_ff <= a_i;
         tail_ff <= b_i;
      end
   end

   // Advance the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_i;
      b_ff   <= b_i;
      deg_ff <= deg_in;
   end

   assign ctl_o = ctl_ff;
   assign a_o   = a_ff;
   assign b_o   = b_ff;
   assign deg_o = deg_ff;

endmodule

FILE: sv/edge_list_graph_table.sv
// An accepted item is registered as a token at the head of the cell chain, walks MAX_EDGES
// cells at one cell a cycle, is held as a pending result, and is offered once the output slot frees.
// Only one item walks the chain at a time: a new item is taken only after the walk and hold end.
// A new item is taken while the previous response still waits on the response channel.
// Reset (synchronous, active high) empties the table and sets vertex_count to 255 and
// directed_mode to 0; stored edge values are not cleared.
`timescale 1ns / 1ps

module edge_list_graph_table
   import elg_pkg::*;
   #(parameter int MAX_EDGES   = MAX_EDGES_DEF,
     parameter int VERTEX_BITS = VERTEX_BITS_DEF)
   (
   input  logic                  clock,
   input  logic                  reset,
   elg_req_if.sink               req_bus,
   elg_rsp_if.source             rsp_bus,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
   );

   localparam int CNT_W = $clog2(MAX_EDGES + 1);
   localparam int DEG_W = $clog2(2 * MAX_EDGES + 1);
   localparam int CMP_W = (VERTEX_BITS > VCOUNT_W) ? VERTEX_BITS : VCOUNT_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_HOLD = 2'd2;

   logic [1:0]             state_ff;
   logic [VCOUNT_W-1:0]    vcount_ff;
   logic                   directed_ff;
   logic [CNT_W-1:0]       total_ff;
   elg_ctl_type            inj_ctl_ff;
   elg_ctl_type            inj_ctl_in;
   logic [VERTEX_BITS-1:0] inj_a_ff;
   logic [VERTEX_BITS-1:0] inj_b_ff;
   logic [STATUS_W-1:0]    pend_status_ff;
   logic [STATUS_W-1:0]    pend_status_in;
   logic                   pend_found_ff;
   logic [DEG_W-1:0]       pend_deg_ff;
   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic                   rsp_found_ff;
   logic [DEG_W-1:0]       rsp_deg_ff;
   logic [CNT_W-1:0]       rsp_held_ff;
   logic                   req_take;
   logic                   a_ok;
   logic                   b_ok;
   logic                   rsp_free;

   elg_ctl_type            ctl_w [0:MAX_EDGES];
   logic [VERTEX_BITS-1:0] a_w   [0:MAX_EDGES];
   logic [VERTEX_BITS-1:0] b_w   [0:MAX_EDGES];
   logic [DEG_W-1:0]       deg_w [0:MAX_EDGES];

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && (state_ff == S_IDLE);
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   // Check both endpoints against 1..vertex_count
   always_comb begin
      a_ok = (req_bus.first_vertex != '0) &&
             (CMP_W'(req_bus.first_vertex) <= CMP_W'(vcount_ff));
      b_ok = (req_bus.second_vertex != '0) &&
             (CMP_W'(req_bus.second_vertex) <= CMP_W'(vcount_ff));
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff   <= VCOUNT_RESET;
         directed_ff <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_VERTEX_COUNT: vcount_ff   <= csr_write_data[VCOUNT_W-1:0];
            REG_DIRECTED:     directed_ff <= csr_write_data[0];
            default:          ;
         endcase
      end
   end

   // Build the token for an accepted item
   always_comb begin
      inj_ctl_in = '0;
      if (req_take) begin
         inj_ctl_in.valid = 1'b1;
         inj_ctl_in.op    = req_bus.operation;
         inj_ctl_in.ins   = (req_bus.operation == OP_INSERT) && a_ok && b_ok;
      end
   end

   // Launch the token into the chain for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         inj_ctl_ff <= '0;
      end else begin
         inj_ctl_ff <= inj_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         inj_a_ff <= req_bus.first_vertex;
         inj_b_ff <= req_bus.second_vertex;
      end
   end

   assign ctl_w[0] = inj_ctl_ff;
   assign a_w[0]   = inj_a_ff;
   assign b_w[0]   = inj_b_ff;
   assign deg_w[0] = '0;

   // Row of edge cells
   for (genvar gi = 0; gi < MAX_EDGES; gi++) begin : g_cell
      elg_cell #(
         .IDX   (gi),
         .VB    (VERTEX_BITS),
         .CNT_W (CNT_W),
         .DEG_W (DEG_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .edge_total (total_ff),
         .directed   (directed_ff),
         .ctl_i      (ctl_w[gi]),
         .a_i        (a_w[gi]),
         .b_i        (b_w[gi]),
         .deg_i      (deg_w[gi]),
         .ctl_o      (ctl_w[gi+1]),
         .a_o        (a_w[gi+1]),
         .b_o        (b_w[gi+1]),
         .deg_o      (deg_w[gi+1])
      );
   end

   // Decode the insert outcome at the end of the chain
   always_comb begin
      pend_status_in = ST_DONE;
      if (ctl_w[MAX_EDGES].op == OP_INSERT) begin
         if (!ctl_w[MAX_EDGES].ins) begin
            pend_status_in = ST_RANGE;
         end else if (ctl_w[MAX_EDGES].found) begin
            pend_status_in = ST_DUPLICATE;
         end else if (!ctl_w[MAX_EDGES].stored) begin
            pend_status_in = ST_FULL;
         end
      end
   end

   // Sequence: idle, walk, hold result until the output slot frees
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_HOLD && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (ctl_w[MAX_EDGES].valid) begin
                  state_ff <= S_HOLD;
                  if (ctl_w[MAX_EDGES].op == OP_CLEAR) begin
                     total_ff <= '0;
                  end else if (ctl_w[MAX_EDGES].stored) begin
                     total_ff <= total_ff + CNT_W'(1);
                  end
               end
            end
            S_HOLD: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (state_ff == S_WALK && ctl_w[MAX_EDGES].valid) begin
         pend_status_ff <= pend_status_in;
         pend_found_ff  <= (ctl_w[MAX_EDGES].op == OP_QUERY) && ctl_w[MAX_EDGES].found;
         pend_deg_ff    <= deg_w[MAX_EDGES];
      end
      if (state_ff == S_HOLD && rsp_free) begin
         rsp_status_ff <= pend_status_ff;
         rsp_found_ff  <= pend_found_ff;
         rsp_deg_ff    <= pend_deg_ff;
         rsp_held_ff   <= total_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.found        = rsp_found_ff;
   assign rsp_bus.degree_count = rsp_deg_ff;
   assign rsp_bus.edges_held   = rsp_held_ff;

   // Checks
   a_tail_in_walk: assert property (@(posedge clock) disable iff (reset)
      ctl_w[MAX_EDGES].valid |-> state_ff == S_WALK)
      else $error("token left the chain outside a walk");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count above table size");

   a_total_moves_at_tail: assert property (@(posedge clock) disable iff (reset)
      !$stable(total_ff) |-> $past(ctl_w[MAX_EDGES].valid))
      else $error("edge count changed without a finished walk");

   a_rsp_from_hold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_HOLD)
      else $error("response raised outside hold");

   a_store_clean: assert property (@(posedge clock) disable iff (reset)
      ctl_w[MAX_EDGES].valid && ctl_w[MAX_EDGES].stored |->
         ctl_w[MAX_EDGES].op == OP_INSERT && !ctl_w[MAX_EDGES].found)
      else $error("edge stored by a non-insert or duplicate");

endmodule
